// ----- sv/bqe_pkg.sv -----
// Shared types and constants for the billboard quad expander.
// Used by bqe_vertex_out and billboard_quad_expander.
// No dependencies.
package bqe_pkg;

  // Corner offsets carry up to 35 bits over the whole fraction-bit range.
  localparam int OFF_W = 36;

  localparam logic [16:0] ONE_Q16 = 17'h10000;

  localparam logic [1:0] CORNER_BL = 2'd0;
  localparam logic [1:0] CORNER_BR = 2'd1;
  localparam logic [1:0] CORNER_TR = 2'd2;
  localparam logic [1:0] CORNER_TL = 2'd3;

  // Finished particle handed to the vertex output stage.
  typedef struct packed {
    logic [2:0][31:0]    pos;
    logic [2:0][OFF_W-1:0] off_r;
    logic [2:0][OFF_W-1:0] off_u;
    logic [31:0]         color;
    logic [16:0]         u0;
    logic [16:0]         u1;
    logic [16:0]         v0;
    logic [16:0]         v1;
  } vtx_t;

  // Payload riding along the age divider.
  typedef struct packed {
    logic [2:0][31:0] pos;
    logic             full;
    logic             zero;
  } age_side_t;

  // Payload riding along the interpolation dividers.
  typedef struct packed {
    logic [2:0][31:0] pos;
  } pos_side_t;

  // Payload riding along the UV dividers.
  typedef struct packed {
    logic [2:0][31:0] pos;
    logic [2:0][32:0] prod_r;
    logic [2:0][32:0] prod_u;
    logic [31:0]      color;
    logic             single;
    logic             u1_full;
    logic             v0_full;
    logic             v1_full;
  } uv_side_t;

endpackage

// ----- sv/bqe_div_pipe.sv -----
// Pipelined restoring divider, one quotient bit per register stage.
// Requires num_i[DW+QW-1:QW] < den_i. Uses no package.
module bqe_div_pipe #(
  parameter int DW = 8,
  parameter int QW = 16,
  parameter int SW = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [DW+QW-1:0]  num_i,
  input  logic [DW-1:0]     den_i,
  input  logic [SW-1:0]     side_i,
  output logic              valid_o,
  output logic [QW-1:0]     quo_o,
  output logic [DW-1:0]     rem_o,
  output logic [SW-1:0]     side_o
);

  logic [QW-1:0] vld_q, vld_d;
  logic [DW-1:0] rem_q  [QW];
  logic [DW-1:0] rem_d  [QW];
  logic [DW-1:0] den_q  [QW];
  logic [DW-1:0] den_d  [QW];
  logic [QW-1:0] low_q  [QW];
  logic [QW-1:0] low_d  [QW];
  logic [QW-1:0] quo_q  [QW];
  logic [QW-1:0] quo_d  [QW];
  logic [SW-1:0] side_q [QW];
  logic [SW-1:0] side_d [QW];

  always_comb begin
    logic [DW-1:0] r;
    logic [DW-1:0] d;
    logic [QW-1:0] n;
    logic [QW-1:0] q;
    logic [DW:0]   trial;
    logic          ge;
    for (int k = 0; k < QW; k++) begin
      if (k == 0) begin
        r = num_i[DW+QW-1:QW];
        n = num_i[QW-1:0];
        q = '0;
        d = den_i;
        side_d[k] = side_i;
        vld_d[k] = valid_i;
      end else begin
        r = rem_q[k-1];
        n = low_q[k-1];
        q = quo_q[k-1];
        d = den_q[k-1];
        side_d[k] = side_q[k-1];
        vld_d[k] = vld_q[k-1];
      end
      trial = {r, n[QW-1]};
      ge = (trial >= {1'b0, d});
      rem_d[k] = ge ? DW'(trial - {1'b0, d}) : trial[DW-1:0];
      low_d[k] = {n[QW-2:0], 1'b0};
      quo_d[k] = {q[QW-2:0], ge};
      den_d[k] = d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < QW; k++) begin
        rem_q[k]  <= rem_d[k];
        den_q[k]  <= den_d[k];
        low_q[k]  <= low_d[k];
        quo_q[k]  <= quo_d[k];
        side_q[k] <= side_d[k];
      end
    end
  end

  assign valid_o = vld_q[QW-1];
  assign quo_o   = quo_q[QW-1];
  assign rem_o   = rem_q[QW-1];
  assign side_o  = side_q[QW-1];

endmodule

// ----- sv/bqe_vertex_out.sv -----
// Output stage: holds one particle and sends its four corner vertices.
// Depends on bqe_pkg (vtx_t, corner codes, OFF_W).
module bqe_vertex_out (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  bqe_pkg::vtx_t   data_i,
  output logic            take_o,
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  // vert_x[31:0], vert_y[63:32], vert_z[95:64], vert_color[127:96],
  // tex_u[144:128], tex_v[161:145], zero fill above
  output logic [167:0]    m_axis_tdata,
  output logic            m_axis_tlast,
  // corner[1:0]
  output logic [1:0]      m_axis_tuser
);

  localparam int SUM_W = bqe_pkg::OFF_W + 2;

  logic          busy_q;
  logic [1:0]    corner_q;
  bqe_pkg::vtx_t vtx_q;

  logic          sign_r, sign_u;
  logic [31:0]   vert [3];
  logic [16:0]   tex_u, tex_v;

  assign take_o = !busy_q || (m_axis_tready && corner_q == bqe_pkg::CORNER_TL);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      corner_q <= bqe_pkg::CORNER_BL;
    end else if (take_o) begin
      busy_q   <= valid_i;
      corner_q <= bqe_pkg::CORNER_BL;
    end else if (m_axis_tready) begin
      corner_q <= 2'(corner_q + 2'd1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      vtx_q <= data_i;
    end
  end

  // right axis positive on BR/TR, up axis positive on TR/TL
  assign sign_r = (corner_q == bqe_pkg::CORNER_BR) || (corner_q == bqe_pkg::CORNER_TR);
  assign sign_u = (corner_q == bqe_pkg::CORNER_TR) || (corner_q == bqe_pkg::CORNER_TL);

  always_comb begin
    logic signed [SUM_W-1:0] p, r, u, s;
    for (int i = 0; i < 3; i++) begin
      p = SUM_W'($signed(vtx_q.pos[i]));
      r = SUM_W'($signed(vtx_q.off_r[i]));
      u = SUM_W'($signed(vtx_q.off_u[i]));
      s = p + (sign_r ? r : -r) + (sign_u ? u : -u);
      if (s > SUM_W'(64'sh7FFFFFFF)) begin
        vert[i] = 32'h7FFF_FFFF;
      end else if (s < -SUM_W'(64'sh80000000)) begin
        vert[i] = 32'h8000_0000;
      end else begin
        vert[i] = s[31:0];
      end
    end
  end

  assign tex_u = sign_r ? vtx_q.u1 : vtx_q.u0;
  assign tex_v = sign_u ? vtx_q.v1 : vtx_q.v0;

  assign m_axis_tvalid = busy_q;
  assign m_axis_tdata  = {6'b0, tex_v, tex_u, vtx_q.color, vert[2], vert[1], vert[0]};
  assign m_axis_tlast  = (corner_q == bqe_pkg::CORNER_TL);
  assign m_axis_tuser  = corner_q;

  ap_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
      (m_axis_tvalid && corner_q == 2'($past(corner_q) + 2'd1)))
    else $error("corner did not advance after transfer");

  ap_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast && !valid_i) |=> !m_axis_tvalid)
    else $error("vertex valid after last corner with nothing loaded");

  ap_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && take_o) |-> (m_axis_tready && m_axis_tlast))
    else $error("particle replaced before its last corner");

endmodule

// ----- sv/billboard_quad_expander.sv -----
// Pipeline: 16-stage age divider, four arithmetic stages, two 16-stage divider banks,
// one offset stage, output register.
// Throughput is set by the four vertex transfers of the output stage per particle;
// the pipeline stalls as a whole while it drains. Config writes are accepted without stall.
// Reset: pipeline valid bits clear, config registers zero except atlas setup = 0x010101.
// Top level; depends on bqe_pkg, bqe_div_pipe and bqe_vertex_out.
module billboard_quad_expander #(
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // pos_x[31:0], pos_y[63:32], pos_z[95:64], life_left[127:96],
  // life_total[158:128], zero fill above
  input  logic [159:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // vert_x[31:0], vert_y[63:32], vert_z[95:64], vert_color[127:96],
  // tex_u[144:128], tex_v[161:145], zero fill above
  output logic [167:0] m_axis_tdata,
  output logic         m_axis_tlast,
  // corner[1:0]
  output logic [1:0]   m_axis_tuser,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [63:0]  cfg_data_i
);

  localparam logic [2:0] REG_COLOR_SM = 3'd0;
  localparam logic [2:0] REG_COLOR_END = 3'd1;
  localparam logic [2:0] REG_KEY_TIMES = 3'd2;
  localparam logic [2:0] REG_KEY_SIZES = 3'd3;
  localparam logic [2:0] REG_RIGHT = 3'd4;
  localparam logic [2:0] REG_UP = 3'd5;
  localparam logic [2:0] REG_ATLAS = 3'd6;

  localparam int PROD_FRAC = 22;
  localparam int SHL = (COORD_FRAC_BITS >= PROD_FRAC) ? COORD_FRAC_BITS - PROD_FRAC : 0;
  localparam int SHR = (COORD_FRAC_BITS < PROD_FRAC) ? PROD_FRAC - COORD_FRAC_BITS : 0;
  localparam int OW = bqe_pkg::OFF_W;

  // ---------------- configuration registers ----------------
  logic [63:0] csm_q;
  logic [31:0] ce_q;
  logic [47:0] kt_q, ks_q, ra_q, ua_q, atlas_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      csm_q   <= '0;
      ce_q    <= '0;
      kt_q    <= '0;
      ks_q    <= '0;
      ra_q    <= '0;
      ua_q    <= '0;
      atlas_q <= 48'h01_0101;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_COLOR_SM:  csm_q   <= cfg_data_i;
        REG_COLOR_END: ce_q    <= cfg_data_i[31:0];
        REG_KEY_TIMES: kt_q    <= cfg_data_i[47:0];
        REG_KEY_SIZES: ks_q    <= cfg_data_i[47:0];
        REG_RIGHT:     ra_q    <= cfg_data_i[47:0];
        REG_UP:        ua_q    <= cfg_data_i[47:0];
        REG_ATLAS:     atlas_q <= cfg_data_i[47:0];
        default: ;
      endcase
    end
  end

  logic [15:0] k0, k1, k2, first_cell, last_cell;
  logic [7:0]  rows_e, cols_e;
  logic [95:0] key_colors;
  logic        single;

  assign k0 = kt_q[15:0];
  assign k1 = kt_q[31:16];
  assign k2 = kt_q[47:32];
  assign first_cell = atlas_q[31:16];
  assign last_cell  = atlas_q[47:32];
  assign rows_e = (atlas_q[7:0] == 8'd0) ? 8'd1 : atlas_q[7:0];
  assign cols_e = (atlas_q[15:8] == 8'd0) ? 8'd1 : atlas_q[15:8];
  assign single = (atlas_q[7:0] <= 8'd1) && (atlas_q[15:8] <= 8'd1);
  assign key_colors = {ce_q, csm_q};

  // ---------------- global advance ----------------
  logic          adv, vo_take, sg_vld_q;
  bqe_pkg::vtx_t sg_q;

  assign adv = vo_take || !sg_vld_q;
  assign s_axis_tready = adv;

  // ---------------- age divider ----------------
  logic signed [31:0] life;
  logic [30:0]        total;
  logic               life_full, life_zero;
  logic [46:0]        age_num;
  bqe_pkg::age_side_t age_side, d1_side;
  logic               d1_vld;
  logic [15:0]        d1_quo;

  assign life  = $signed(s_axis_tdata[127:96]);
  assign total = s_axis_tdata[158:128];
  assign life_full = life[31] || (life == 32'sd0);
  assign life_zero = !life_full && (life[30:0] >= total);
  assign age_num = (life_full || life_zero) ? '0 : {life[30:0], 16'b0};
  assign age_side.pos  = s_axis_tdata[95:0];
  assign age_side.full = life_full;
  assign age_side.zero = life_zero;

  bqe_div_pipe #(.DW(31), .QW(16), .SW($bits(bqe_pkg::age_side_t))) u_div_age (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(s_axis_tvalid),
    .num_i(age_num), .den_i(total), .side_i(age_side),
    .valid_o(d1_vld), .quo_o(d1_quo), .rem_o(), .side_o(d1_side)
  );

  // ---------------- stage B: age ----------------
  logic             sb_vld_q;
  logic [16:0]      sb_t_q;
  logic [2:0][31:0] sb_pos_q;

  // ---------------- stage C: segment select ----------------
  logic             sc_vld_q;
  logic [16:0]      sc_t_q;
  logic [2:0][31:0] sc_pos_q;
  logic [15:0]      sc_sa_q, sc_sb_q, sc_num_q, sc_den_q, sc_diff_q;
  logic [31:0]      sc_ca_q, sc_cb_q;
  logic [15:0]      sc_num_d, sc_den_d;
  logic [1:0]       ia, ib;

  always_comb begin
    ia = 2'd0;
    ib = 2'd0;
    sc_num_d = '0;
    sc_den_d = 16'd1;
    priority if (sb_t_q <= {1'b0, k0}) begin
      ia = 2'd0;
    end else if (sb_t_q >= {1'b0, k2}) begin
      ia = 2'd2;
      ib = 2'd2;
    end else if (sb_t_q <= {1'b0, k1}) begin
      ib = 2'd1;
      sc_num_d = 16'(sb_t_q - {1'b0, k0});
      sc_den_d = k1 - k0;
    end else begin
      ia = 2'd1;
      ib = 2'd2;
      sc_num_d = 16'(sb_t_q - {1'b0, k1});
      sc_den_d = k2 - k1;
    end
  end

  // ---------------- stage D: products ----------------
  logic             sd_vld_q;
  logic [2:0][31:0] sd_pos_q;
  logic [15:0]      sd_den_q;
  logic [31:0]      sd_spa_q, sd_spb_q;
  logic [23:0]      sd_cpa_q [4];
  logic [23:0]      sd_cpb_q [4];
  logic [32:0]      sd_cprod_q;

  // ---------------- stage E: sums and cell ----------------
  logic             se_vld_q;
  logic [2:0][31:0] se_pos_q;
  logic [15:0]      se_den_q, se_cell_q;
  logic [31:0]      se_snum_q;
  logic [23:0]      se_cnum_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sb_vld_q <= 1'b0;
      sc_vld_q <= 1'b0;
      sd_vld_q <= 1'b0;
      se_vld_q <= 1'b0;
    end else if (adv) begin
      sb_vld_q <= d1_vld;
      sc_vld_q <= sb_vld_q;
      sd_vld_q <= sc_vld_q;
      se_vld_q <= sd_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sb_pos_q <= d1_side.pos;
      if (d1_side.full) begin
        sb_t_q <= bqe_pkg::ONE_Q16;
      end else if (d1_side.zero) begin
        sb_t_q <= '0;
      end else begin
        sb_t_q <= 17'(bqe_pkg::ONE_Q16 - {1'b0, d1_quo});
      end

      sc_t_q    <= sb_t_q;
      sc_pos_q  <= sb_pos_q;
      sc_num_q  <= sc_num_d;
      sc_den_q  <= sc_den_d;
      sc_sa_q   <= ks_q[16*ia +: 16];
      sc_sb_q   <= ks_q[16*ib +: 16];
      sc_ca_q   <= key_colors[32*ia +: 32];
      sc_cb_q   <= key_colors[32*ib +: 32];
      sc_diff_q <= (last_cell > first_cell) ? 16'(last_cell - first_cell) : 16'd0;

      sd_pos_q   <= sc_pos_q;
      sd_den_q   <= sc_den_q;
      sd_spa_q   <= 32'(sc_sa_q) * 32'(16'(sc_den_q - sc_num_q));
      sd_spb_q   <= 32'(sc_sb_q) * 32'(sc_num_q);
      for (int c = 0; c < 4; c++) begin
        sd_cpa_q[c] <= 24'(sc_ca_q[8*c +: 8]) * 24'(16'(sc_den_q - sc_num_q));
        sd_cpb_q[c] <= 24'(sc_cb_q[8*c +: 8]) * 24'(sc_num_q);
      end
      sd_cprod_q <= 33'(sc_t_q) * 33'(sc_diff_q);

      se_pos_q  <= sd_pos_q;
      se_den_q  <= sd_den_q;
      se_snum_q <= sd_spa_q + sd_spb_q;
      for (int c = 0; c < 4; c++) begin
        se_cnum_q[c] <= sd_cpa_q[c] + sd_cpb_q[c];
      end
      // t * (last - first) >> 16 never exceeds last - first
      se_cell_q <= 16'(first_cell + sd_cprod_q[32:16]);
    end
  end

  // ---------------- interpolation and cell dividers ----------------
  bqe_pkg::pos_side_t d2_side_in, d2_side;
  logic               d2_vld;
  logic [15:0]        d2_size, d2_row;
  logic [15:0]        d2_col_q [4];
  logic [7:0]         d2_col;

  assign d2_side_in.pos = se_pos_q;

  bqe_div_pipe #(.DW(16), .QW(16), .SW($bits(bqe_pkg::pos_side_t))) u_div_size (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(se_vld_q),
    .num_i(se_snum_q), .den_i(se_den_q), .side_i(d2_side_in),
    .valid_o(d2_vld), .quo_o(d2_size), .rem_o(), .side_o(d2_side)
  );

  for (genvar c = 0; c < 4; c++) begin : g_color
    bqe_div_pipe #(.DW(16), .QW(16), .SW(1)) u_div_color (
      .clk_i, .rst_ni, .en_i(adv), .valid_i(se_vld_q),
      .num_i({8'b0, se_cnum_q[c]}), .den_i(se_den_q), .side_i(1'b0),
      .valid_o(), .quo_o(d2_col_q[c]), .rem_o(), .side_o()
    );
  end

  bqe_div_pipe #(.DW(8), .QW(16), .SW(1)) u_div_cell (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(se_vld_q),
    .num_i({8'b0, se_cell_q}), .den_i(cols_e), .side_i(1'b0),
    .valid_o(), .quo_o(d2_row), .rem_o(d2_col), .side_o()
  );

  // ---------------- axis products and UV divider setup ----------------
  bqe_pkg::uv_side_t uv_side, d3_side;
  logic [8:0]  col_inc;
  logic [16:0] row_inc;
  logic [23:0] u0_num, u1_num, v0_num, v1_num;

  assign col_inc = {1'b0, d2_col} + 9'd1;
  assign row_inc = {1'b0, d2_row} + 17'd1;

  always_comb begin
    logic signed [16:0] sz;
    sz = $signed({1'b0, d2_size});
    for (int i = 0; i < 3; i++) begin
      uv_side.prod_r[i] = 33'($signed(ra_q[16*i +: 16]) * sz);
      uv_side.prod_u[i] = 33'($signed(ua_q[16*i +: 16]) * sz);
    end
    uv_side.pos     = d2_side.pos;
    uv_side.color   = {d2_col_q[3][7:0], d2_col_q[2][7:0], d2_col_q[1][7:0], d2_col_q[0][7:0]};
    uv_side.single  = single;
    uv_side.u1_full = (col_inc >= {1'b0, cols_e});
    uv_side.v0_full = (d2_row >= {8'b0, rows_e});
    uv_side.v1_full = (row_inc >= {9'b0, rows_e});
  end

  assign u0_num = {d2_col, 16'b0};
  assign u1_num = uv_side.u1_full ? '0 : {col_inc[7:0], 16'b0};
  assign v0_num = uv_side.v0_full ? '0 : {d2_row[7:0], 16'b0};
  assign v1_num = uv_side.v1_full ? '0 : {row_inc[7:0], 16'b0};

  logic        d3_vld;
  logic [15:0] q_u0, q_u1, q_v0, q_v1;

  bqe_div_pipe #(.DW(8), .QW(16), .SW($bits(bqe_pkg::uv_side_t))) u_div_u0 (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(d2_vld),
    .num_i(u0_num), .den_i(cols_e), .side_i(uv_side),
    .valid_o(d3_vld), .quo_o(q_u0), .rem_o(), .side_o(d3_side)
  );

  bqe_div_pipe #(.DW(8), .QW(16), .SW(1)) u_div_u1 (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(d2_vld),
    .num_i(u1_num), .den_i(cols_e), .side_i(1'b0),
    .valid_o(), .quo_o(q_u1), .rem_o(), .side_o()
  );

  bqe_div_pipe #(.DW(8), .QW(16), .SW(1)) u_div_v0 (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(d2_vld),
    .num_i(v0_num), .den_i(rows_e), .side_i(1'b0),
    .valid_o(), .quo_o(q_v0), .rem_o(), .side_o()
  );

  bqe_div_pipe #(.DW(8), .QW(16), .SW(1)) u_div_v1 (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(d2_vld),
    .num_i(v1_num), .den_i(rows_e), .side_i(1'b0),
    .valid_o(), .quo_o(q_v1), .rem_o(), .side_o()
  );

  // ---------------- stage G: offsets and UV ----------------
  bqe_pkg::vtx_t sg_d;

  always_comb begin
    logic signed [OW-1:0] er, eu;
    for (int i = 0; i < 3; i++) begin
      er = OW'($signed(d3_side.prod_r[i]));
      eu = OW'($signed(d3_side.prod_u[i]));
      // floor shift right or exact shift left to the coordinate format
      sg_d.off_r[i] = (er <<< SHL) >>> SHR;
      sg_d.off_u[i] = (eu <<< SHL) >>> SHR;
    end
    sg_d.pos   = d3_side.pos;
    sg_d.color = d3_side.color;
    if (d3_side.single) begin
      sg_d.u0 = '0;
      sg_d.u1 = bqe_pkg::ONE_Q16;
      sg_d.v0 = '0;
      sg_d.v1 = bqe_pkg::ONE_Q16;
    end else begin
      sg_d.u0 = {1'b0, q_u0};
      sg_d.u1 = d3_side.u1_full ? bqe_pkg::ONE_Q16 : {1'b0, q_u1};
      sg_d.v0 = d3_side.v0_full ? bqe_pkg::ONE_Q16 : {1'b0, q_v0};
      sg_d.v1 = d3_side.v1_full ? bqe_pkg::ONE_Q16 : {1'b0, q_v1};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sg_vld_q <= 1'b0;
    end else if (adv) begin
      sg_vld_q <= d3_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sg_q <= sg_d;
    end
  end

  // ---------------- vertex output ----------------
  bqe_vertex_out u_vertex_out (
    .clk_i, .rst_ni,
    .valid_i(sg_vld_q), .data_i(sg_q), .take_o(vo_take),
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast, .m_axis_tuser
  );

endmodule
